// File: rtl/core/tmpds_pkg.sv
package tmpds_pkg;

  // Sample framing
  localparam int SAMPLES_PER_AXIS = 5;
  localparam int SAMPLE_W         = 10;
  localparam int POS_W            = $clog2(SAMPLES_PER_AXIS);
  localparam int RANK_W           = $clog2(SAMPLES_PER_AXIS);
  localparam int MED_RANK         = SAMPLES_PER_AXIS / 2;
  localparam int BUF_DEPTH        = SAMPLES_PER_AXIS - 1;

  // Calibration arithmetic
  localparam int SCALE_W = 16;
  localparam int OFF_W   = 16;
  localparam int FRAC_W  = 14;
  localparam int PROD_W  = SAMPLE_W + SCALE_W;
  localparam int ACC_W   = 32;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_SCALE     = 3'd0,
    CFG_Y_SCALE     = 3'd1,
    CFG_X_OFFSET    = 3'd2,
    CFG_Y_OFFSET    = 3'd3,
    CFG_X_THRESHOLD = 3'd4,
    CFG_Y_THRESHOLD = 3'd5,
    CFG_PANEL_WIDTH = 3'd6
  } cfg_reg_t;

  // Reset values of the calibration registers
  localparam logic [SCALE_W-1:0]         RST_X_SCALE     = 16'd6407;
  localparam logic [SCALE_W-1:0]         RST_Y_SCALE     = 16'd4935;
  localparam logic signed [OFF_W-1:0]    RST_X_OFFSET    = 16'sd44;
  localparam logic signed [OFF_W-1:0]    RST_Y_OFFSET    = 16'sd40;
  localparam logic [SAMPLE_W-1:0]        RST_X_THRESHOLD = 10'd70;
  localparam logic [SAMPLE_W-1:0]        RST_Y_THRESHOLD = 10'd120;
  localparam logic [SAMPLE_W-1:0]        RST_PANEL_WIDTH = 10'd320;

  typedef struct packed {
    logic [SCALE_W-1:0]      x_scale;
    logic [SCALE_W-1:0]      y_scale;
    logic signed [OFF_W-1:0] x_offset;
    logic signed [OFF_W-1:0] y_offset;
    logic [SAMPLE_W-1:0]     x_threshold;
    logic [SAMPLE_W-1:0]     y_threshold;
    logic [SAMPLE_W-1:0]     panel_width;
  } cfg_t;

  // One finished set: both medians
  typedef struct packed {
    logic [SAMPLE_W-1:0] x_med;
    logic [SAMPLE_W-1:0] y_med;
  } job_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

endpackage

// File: rtl/core/tmpds_in_if.sv
interface tmpds_in_if import tmpds_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                start_req;

  modport source(output valid, sample, start_req, input ready);
  modport sink(input valid, sample, start_req, output ready);
endinterface

// File: rtl/core/tmpds_out_if.sv
interface tmpds_out_if import tmpds_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                pressed;
  logic [SAMPLE_W-1:0] x_pos;
  logic [SAMPLE_W-1:0] y_pos;

  modport source(output valid, pressed, x_pos, y_pos, input ready);
  modport sink(input valid, pressed, x_pos, y_pos, output ready);
endinterface

// File: rtl/core/touch_median_pen_detect_scaler.sv
// Resistive touch filter: takes one ADC sample per beat, five X samples and
// then five Y samples per set (start_req restarts a set at X sample 0), and
// after the tenth sample gives one result with the pen-down flag and both
// calibrated positions. While the queue has room a sample is taken every
// cycle; each set thus costs ten input beats and yields one output beat.
// The median of each group is found by a combinational ranking network on
// the incoming sample plus the four stored ones. Finished sets wait in a
// two-entry queue, and the back end registers the gain multiply and then
// the offset, mirror and clamp. Input stalls only when two finished sets
// are queued behind a blocked output. Calibration registers are written
// via cfg_we/cfg_index/cfg_wdata; the user must write them only while no
// set is in flight (not enforced by the block). Unknown indexes are ignored.
module touch_median_pen_detect_scaler import tmpds_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  tmpds_in_if.sink              in_ch,
  tmpds_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg_r;
  q_stat_t q_stat;
  logic    push, pop;
  job_t    push_job, pop_job;

  // Calibration register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_scale     <= RST_X_SCALE;
      cfg_r.y_scale     <= RST_Y_SCALE;
      cfg_r.x_offset    <= RST_X_OFFSET;
      cfg_r.y_offset    <= RST_Y_OFFSET;
      cfg_r.x_threshold <= RST_X_THRESHOLD;
      cfg_r.y_threshold <= RST_Y_THRESHOLD;
      cfg_r.panel_width <= RST_PANEL_WIDTH;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_X_SCALE:     cfg_r.x_scale     <= cfg_wdata[SCALE_W-1:0];
        CFG_Y_SCALE:     cfg_r.y_scale     <= cfg_wdata[SCALE_W-1:0];
        CFG_X_OFFSET:    cfg_r.x_offset    <= signed'(cfg_wdata[OFF_W-1:0]);
        CFG_Y_OFFSET:    cfg_r.y_offset    <= signed'(cfg_wdata[OFF_W-1:0]);
        CFG_X_THRESHOLD: cfg_r.x_threshold <= cfg_wdata[SAMPLE_W-1:0];
        CFG_Y_THRESHOLD: cfg_r.y_threshold <= cfg_wdata[SAMPLE_W-1:0];
        CFG_PANEL_WIDTH: cfg_r.panel_width <= cfg_wdata[SAMPLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tmpds_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  tmpds_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_stat   (q_stat)
  );

  tmpds_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_stat  (q_stat),
    .pop_job (pop_job),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

// File: rtl/core/tmpds_front.sv
module tmpds_front import tmpds_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  tmpds_in_if.sink     in_ch,
  input  q_stat_t      q_stat,
  output logic         push,
  output job_t         push_job
);

  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                axis_r, axis_nxt;
  logic [SAMPLE_W-1:0] x_med_r;
  logic [SAMPLE_W-1:0] buf_r [BUF_DEPTH];

  logic                accept;
  logic [POS_W-1:0]    eff_pos;
  logic                eff_axis;
  logic                group_done;
  logic [SAMPLE_W-1:0] vals [SAMPLES_PER_AXIS];
  logic [RANK_W-1:0]   rank [SAMPLES_PER_AXIS];
  logic [SAMPLE_W-1:0] median;

  // A beat is taken whenever the queue has room for a finished set.
  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  // A start request makes this beat the first X sample.
  assign eff_pos    = in_ch.start_req ? '0 : pos_r;
  assign eff_axis   = in_ch.start_req ? 1'b0 : axis_r;
  assign group_done = (eff_pos == POS_W'(SAMPLES_PER_AXIS - 1));

  // The group is the stored samples plus the one arriving now.
  always_comb begin
    for (int k = 0; k < BUF_DEPTH; k++) begin
      vals[k] = buf_r[k];
    end
    vals[SAMPLES_PER_AXIS-1] = in_ch.sample;
  end

  // Rank each sample by counting smaller ones; equal values are ordered by
  // position, so exactly one sample carries the middle rank.
  always_comb begin
    median = '0;
    for (int i = 0; i < SAMPLES_PER_AXIS; i++) begin
      rank[i] = '0;
      for (int j = 0; j < SAMPLES_PER_AXIS; j++) begin
        if ((vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i))) begin
          rank[i] = rank[i] + RANK_W'(1);
        end
      end
      if (rank[i] == RANK_W'(MED_RANK)) begin
        median = median | vals[i];
      end
    end
  end

  // Position in the set after this beat.
  always_comb begin
    pos_nxt  = pos_r;
    axis_nxt = axis_r;
    if (accept) begin
      if (group_done) begin
        pos_nxt  = '0;
        axis_nxt = !eff_axis;
      end else begin
        pos_nxt  = eff_pos + POS_W'(1);
        axis_nxt = eff_axis;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      axis_r  <= 1'b0;
      x_med_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      axis_r <= axis_nxt;
      if (accept && group_done && !eff_axis) begin
        x_med_r <= median;
      end
    end
  end

  // Sample store; the last sample of a group is never stored.
  always_ff @(posedge clk) begin
    for (int k = 0; k < BUF_DEPTH; k++) begin
      if (accept && (eff_pos == POS_W'(k))) begin
        buf_r[k] <= in_ch.sample;
      end
    end
  end

  // The last Y sample hands the set to the back end.
  assign push           = accept && group_done && eff_axis;
  assign push_job.x_med = x_med_r;
  assign push_job.y_med = median;

endmodule

// File: rtl/core/tmpds_queue.sv
module tmpds_queue import tmpds_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    pop_job,
  output q_stat_t q_stat
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] n;
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + QPTR_W'(1);
    end
    return n;
  endfunction

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= next_ptr(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= next_ptr(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  assign pop_job          = mem_r[rd_ptr_r];
  assign q_stat.full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.not_empty = (cnt_r != '0);

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < QCNT_W'(QUEUE_DEPTH)))
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("queue read while empty");

endmodule

// File: rtl/core/tmpds_back.sv
module tmpds_back import tmpds_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  q_stat_t    q_stat,
  input  job_t       pop_job,
  output logic       pop,
  tmpds_out_if.source out_ch
);

  logic                s1_valid_r;
  logic                s1_pressed_r;
  logic [PROD_W-1:0]   px_r, py_r;
  logic                out_valid_r;
  logic                out_pressed_r;
  logic [SAMPLE_W-1:0] out_x_r, out_y_r;

  logic                out_load;
  logic                s1_ready;
  logic signed [ACC_W-1:0] vx, vy;
  logic signed [ACC_W-1:0] x_off_q, y_off_q;

  // Negative gives zero; otherwise drop the fraction and saturate.
  function automatic logic [SAMPLE_W-1:0] clamp_q(input logic signed [ACC_W-1:0] v);
    logic [SAMPLE_W-1:0] r;
    if (v[ACC_W-1]) begin
      r = '0;
    end else if (|v[ACC_W-2:FRAC_W+SAMPLE_W]) begin
      r = '1;
    end else begin
      r = v[FRAC_W+SAMPLE_W-1:FRAC_W];
    end
    return r;
  endfunction

  // Flow control: the output register frees when empty or taken.
  assign out_load = !out_valid_r || out_ch.ready;
  assign s1_ready = !s1_valid_r || out_load;
  assign pop      = q_stat.not_empty && s1_ready;

  // Stage 1: pen detect and the two gain multiplies.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (pop) begin
      s1_valid_r <= 1'b1;
    end else if (out_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_pressed_r <= (pop_job.x_med >= cfg.x_threshold) &&
                      (pop_job.y_med >= cfg.y_threshold);
      px_r <= PROD_W'(pop_job.x_med) * PROD_W'(cfg.x_scale);
      py_r <= PROD_W'(pop_job.y_med) * PROD_W'(cfg.y_scale);
    end
  end

  // Stage 2: offsets and mirror in Q14, then clamp.
  assign x_off_q = {{(ACC_W-OFF_W-FRAC_W){cfg.x_offset[OFF_W-1]}}, cfg.x_offset,
                    {FRAC_W{1'b0}}};
  assign y_off_q = {{(ACC_W-OFF_W-FRAC_W){cfg.y_offset[OFF_W-1]}}, cfg.y_offset,
                    {FRAC_W{1'b0}}};

  always_comb begin
    vx = signed'({{(ACC_W-SAMPLE_W-FRAC_W){1'b0}}, cfg.panel_width, {FRAC_W{1'b0}}})
         - signed'(ACC_W'(px_r)) + x_off_q;
    vy = signed'(ACC_W'(py_r)) - y_off_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid_r) begin
      out_pressed_r <= s1_pressed_r;
      out_x_r       <= s1_pressed_r ? clamp_q(vx) : '0;
      out_y_r       <= s1_pressed_r ? clamp_q(vy) : '0;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.pressed = out_pressed_r;
  assign out_ch.x_pos   = out_x_r;
  assign out_ch.y_pos   = out_y_r;

  a_pen_up_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pressed_r) |-> ((out_x_r == '0) && (out_y_r == '0)))
    else $error("position reported with pen up");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_load) |=> s1_valid_r)
    else $error("stage 1 result dropped while output stalled");

endmodule

// File: bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tmpds_pkg::*;

  // Register index that lies beyond the calibration register list.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
  localparam int SET_LEN     = 2 * SAMPLES_PER_AXIS;
  localparam int POS_LIMIT   = 1023;
  localparam int RANDOM_GOAL = 1500;
  localparam int PHASE_LEN   = 250;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                start_req;
  } touch_sample_t;

  typedef struct packed {
    logic                pressed;
    logic [SAMPLE_W-1:0] x_pos;
    logic [SAMPLE_W-1:0] y_pos;
  } touch_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tmpds_in_if  in_ch();
  tmpds_out_if out_ch();

  touch_median_pen_detect_scaler DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Samples waiting to be driven and reports the filter should produce.
  touch_sample_t pending_q[$];
  touch_report_t touch_reports_q[$];

  int samples_queued = 0;
  int samples_taken  = 0;
  int failures       = 0;
  int gen_pos        = 0;
  logic in_taken     = 1'b0;

  // Predictor state: calibration registers and the filter's own set tracking.
  cfg_t                cal_regs;
  logic [SAMPLE_W-1:0] sample_hist [SAMPLES_PER_AXIS];
  logic [SAMPLE_W-1:0] x_med_held;
  int                  set_pos;

  function automatic logic [SAMPLE_W-1:0] group_median();
    logic [SAMPLE_W-1:0] v [SAMPLES_PER_AXIS];
    logic [SAMPLE_W-1:0] key;
    int j;
    v = sample_hist;
    for (int i = 1; i < SAMPLES_PER_AXIS; i++) begin
      key = v[i];
      j = i - 1;
      while (j >= 0 && v[j] > key) begin
        v[j + 1] = v[j];
        j--;
      end
      v[j + 1] = key;
    end
    return v[MED_RANK];
  endfunction

  // Q14 value to a position: negative gives 0, otherwise truncate and saturate.
  function automatic logic [SAMPLE_W-1:0] q14_to_position(input longint q);
    longint p;
    if (q < 0) return '0;
    p = q >>> FRAC_W;
    if (p > POS_LIMIT) p = POS_LIMIT;
    return p[SAMPLE_W-1:0];
  endfunction

  // Advance the predicted filter by one accepted sample beat.
  function automatic void absorb_sample(input logic [SAMPLE_W-1:0] s, input logic start);
    logic [SAMPLE_W-1:0] y_med;
    touch_report_t       rep;
    longint              vx, vy;
    if (start) set_pos = 0;
    if (set_pos >= SET_LEN) set_pos = 0;
    sample_hist[set_pos % SAMPLES_PER_AXIS] = s;
    if (set_pos == SAMPLES_PER_AXIS - 1) x_med_held = group_median();
    if (set_pos != SET_LEN - 1) begin
      set_pos++;
      return;
    end
    set_pos = 0;
    y_med = group_median();
    rep = '0;
    rep.pressed = (x_med_held >= cal_regs.x_threshold) && (y_med >= cal_regs.y_threshold);
    if (rep.pressed) begin
      vx = longint'(cal_regs.panel_width) * 16384
           - longint'(x_med_held) * longint'(cal_regs.x_scale)
           + longint'($signed(cal_regs.x_offset)) * 16384;
      vy = longint'(y_med) * longint'(cal_regs.y_scale)
           - longint'($signed(cal_regs.y_offset)) * 16384;
      rep.x_pos = q14_to_position(vx);
      rep.y_pos = q14_to_position(vy);
    end
    touch_reports_q.push_back(rep);
  endfunction

  function automatic void check_field(input string what, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      failures++;
    end
  endfunction

  // Monitor: check report beats against the oldest prediction, then predict from
  // the sample beat taken at this edge.
  always @(posedge clk) begin : watch_beats
    touch_report_t want;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (touch_reports_q.size() == 0) begin
        $display("%0t ns: unexpected report, expected none, actual pressed %0d x %0d y %0d",
                 $time, out_ch.pressed, out_ch.x_pos, out_ch.y_pos);
        failures++;
      end else begin
        want = touch_reports_q.pop_front();
        check_field("pressed", want.pressed, out_ch.pressed);
        check_field("x_pos", want.x_pos, out_ch.x_pos);
        check_field("y_pos", want.y_pos, out_ch.y_pos);
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      samples_taken++;
      absorb_sample(in_ch.sample, in_ch.start_req);
    end
  end

  // Sample driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin : drive_samples
    touch_sample_t nxt;
    logic          send;
    send = 1'b0;
    nxt.sample    = SAMPLE_W'($urandom_range(0, POS_LIMIT));
    nxt.start_req = 1'($urandom_range(0, 1));
    if (!(in_ch.valid && !in_taken)) begin
      if (rst_n && gap_left > 0) begin
        gap_left--;
      end else if (rst_n && pending_q.size() > 0) begin
        nxt = pending_q.pop_front();
        send = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      in_ch.valid     <= send;
      in_ch.sample    <= nxt.sample;
      in_ch.start_req <= nxt.start_req;
    end
  end

  // Report receiver: ready follows the bits of a 16-bit pattern in turn, redrawn once all are used.
  logic [15:0] ready_bits = '1;
  int          ready_idx  = 0;

  always @(negedge clk) begin : drive_ready
    if (ready_idx == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_bits = '1;
        1:       ready_bits = 16'($urandom);
        2:       ready_bits = 16'($urandom | $urandom);
        default: ready_bits = 16'($urandom & $urandom);
      endcase
    end
    out_ch.ready <= ready_bits[ready_idx];
    ready_idx = (ready_idx + 1) % 16;
  end

  task automatic write_cal(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_X_SCALE:     cal_regs.x_scale     = data;
      CFG_Y_SCALE:     cal_regs.y_scale     = data;
      CFG_X_OFFSET:    cal_regs.x_offset    = data;
      CFG_Y_OFFSET:    cal_regs.y_offset    = data;
      CFG_X_THRESHOLD: cal_regs.x_threshold = data[SAMPLE_W-1:0];
      CFG_Y_THRESHOLD: cal_regs.y_threshold = data[SAMPLE_W-1:0];
      CFG_PANEL_WIDTH: cal_regs.panel_width = data[SAMPLE_W-1:0];
      default: ;
    endcase
  endtask

  // Calibration settings per phase, from typical values to the register extremes.
  task automatic configure_phase(input int k);
    case (k % 6)
      0, 5: begin
        write_cal(CFG_X_SCALE, 16'($urandom_range(2000, 12000)));
        write_cal(CFG_Y_SCALE, 16'($urandom_range(2000, 12000)));
        write_cal(CFG_X_OFFSET, 16'(int'($urandom_range(0, 400)) - 200));
        write_cal(CFG_Y_OFFSET, 16'(int'($urandom_range(0, 400)) - 200));
        write_cal(CFG_X_THRESHOLD, 16'($urandom_range(0, 200)));
        write_cal(CFG_Y_THRESHOLD, 16'($urandom_range(0, 200)));
        write_cal(CFG_PANEL_WIDTH, 16'($urandom_range(200, POS_LIMIT)));
        write_cal(CFG_SPARE_IDX, 16'($urandom));
      end
      1: begin
        write_cal(CFG_X_SCALE, 16'h0000);
        write_cal(CFG_Y_SCALE, 16'h0000);
        write_cal(CFG_X_OFFSET, 16'h8000);
        write_cal(CFG_Y_OFFSET, 16'h8000);
        write_cal(CFG_X_THRESHOLD, 16'h0000);
        write_cal(CFG_Y_THRESHOLD, 16'h0000);
        write_cal(CFG_PANEL_WIDTH, 16'h0000);
      end
      2: begin
        write_cal(CFG_X_SCALE, 16'hFFFF);
        write_cal(CFG_Y_SCALE, 16'hFFFF);
        write_cal(CFG_X_OFFSET, 16'h7FFF);
        write_cal(CFG_Y_OFFSET, 16'h7FFF);
        write_cal(CFG_X_THRESHOLD, 16'hFFFF);
        write_cal(CFG_Y_THRESHOLD, 16'hFFFF);
        write_cal(CFG_PANEL_WIDTH, 16'hFFFF);
      end
      3: begin
        write_cal(CFG_X_SCALE, 16'($urandom));
        write_cal(CFG_Y_SCALE, 16'($urandom));
        write_cal(CFG_X_OFFSET, 16'($urandom));
        write_cal(CFG_Y_OFFSET, 16'($urandom));
        write_cal(CFG_X_THRESHOLD, 16'($urandom));
        write_cal(CFG_Y_THRESHOLD, 16'($urandom));
        write_cal(CFG_PANEL_WIDTH, 16'($urandom));
      end
      default: begin
        write_cal(CFG_X_SCALE, 16'hFFFF);
        write_cal(CFG_Y_SCALE, 16'h0000);
        write_cal(CFG_X_OFFSET, 16'h8000);
        write_cal(CFG_Y_OFFSET, 16'h7FFF);
        write_cal(CFG_X_THRESHOLD, 16'h0000);
        write_cal(CFG_Y_THRESHOLD, 16'h03FF);
        write_cal(CFG_PANEL_WIDTH, 16'h03FF);
      end
    endcase
  endtask

  // Queue one sample and keep track of where it falls within a set.
  task automatic queue_sample(input int s, input bit start);
    touch_sample_t it;
    it.sample    = s[SAMPLE_W-1:0];
    it.start_req = start;
    pending_q.push_back(it);
    samples_queued++;
    if (start) gen_pos = 0;
    gen_pos = (gen_pos + 1) % SET_LEN;
  endtask

  // One axis worth of samples: clustered with outliers, uniform, rail to rail,
  // or clustered right at the pen threshold.
  task automatic queue_group(input int level, input bit start);
    int mode, center, v;
    case ($urandom_range(0, 19))
      0, 1, 2:    mode = 1;
      3, 4, 5:    mode = 2;
      6, 7, 8, 9: mode = 3;
      default:    mode = 0;
    endcase
    center = (mode == 3) ? level + int'($urandom_range(0, 4)) - 2
                         : int'($urandom_range(0, POS_LIMIT));
    for (int i = 0; i < SAMPLES_PER_AXIS; i++) begin
      case (mode)
        0: begin
          v = center + int'($urandom_range(0, 30)) - 15;
          if ($urandom_range(0, 4) == 0) v = $urandom_range(0, POS_LIMIT);
        end
        1:       v = $urandom_range(0, POS_LIMIT);
        2:       v = ($urandom_range(0, 1) == 1) ? POS_LIMIT : 0;
        default: v = center + int'($urandom_range(0, 2)) - 1;
      endcase
      if (v < 0) v = 0;
      if (v > POS_LIMIT) v = POS_LIMIT;
      queue_sample(v, start && (i == 0));
    end
  endtask

  // Mostly complete sets; some broken fragments and some start-request noise.
  task automatic queue_random_stimulus();
    int r, n;
    r = $urandom_range(0, 19);
    if (r < 2) begin
      n = $urandom_range(1, SET_LEN - 1);
      repeat (n) queue_sample($urandom_range(0, POS_LIMIT), 1'b0);
    end else if (r == 2) begin
      repeat (SET_LEN) queue_sample($urandom_range(0, POS_LIMIT), $urandom_range(0, 7) == 0);
    end else begin
      queue_group(cal_regs.x_threshold, (gen_pos != 0) || ($urandom_range(0, 1) == 1));
      queue_group(cal_regs.y_threshold, 1'b0);
    end
  endtask

  // Hold the sender until every queued sample is taken and every report is in,
  // then leave room for the back end to settle.
  task automatic wait_for_drain();
    while (samples_taken != samples_queued || touch_reports_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin : run_test
    int phase_start, random_items;
    bit paused;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.sample    = '0;
    in_ch.start_req = 1'b0;
    out_ch.ready    = 1'b0;
    cal_regs = '{x_scale: RST_X_SCALE, y_scale: RST_Y_SCALE, x_offset: RST_X_OFFSET,
                 y_offset: RST_Y_OFFSET, x_threshold: RST_X_THRESHOLD,
                 y_threshold: RST_Y_THRESHOLD, panel_width: RST_PANEL_WIDTH};
    foreach (sample_hist[i]) sample_hist[i] = '0;
    x_med_held = '0;
    set_pos    = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: medians exactly at both pen thresholds, then a fragment cut off
    // by a start request, then a Y median one below its threshold.
    queue_sample(70, 1'b0);   queue_sample(1023, 1'b0); queue_sample(70, 1'b0);
    queue_sample(0, 1'b0);    queue_sample(70, 1'b0);
    queue_sample(120, 1'b0);  queue_sample(120, 1'b0);  queue_sample(1023, 1'b0);
    queue_sample(0, 1'b0);    queue_sample(500, 1'b0);
    queue_sample(1023, 1'b0); queue_sample(0, 1'b0);    queue_sample(512, 1'b0);
    queue_sample(5, 1'b1);    queue_sample(900, 1'b0);  queue_sample(300, 1'b0);
    queue_sample(1023, 1'b0); queue_sample(0, 1'b0);
    queue_sample(0, 1'b0);    queue_sample(0, 1'b0);    queue_sample(1023, 1'b0);
    queue_sample(1023, 1'b0); queue_sample(119, 1'b0);
    wait_for_drain();

    // Random phases, each under its own calibration and paused once midway.
    random_items = 0;
    for (int k = 0; random_items < RANDOM_GOAL; k++) begin
      configure_phase(k);
      phase_start = samples_queued;
      paused = 1'b0;
      while (samples_queued - phase_start < PHASE_LEN) begin
        if (!paused && samples_queued - phase_start >= PHASE_LEN / 2) begin
          wait_for_drain();
          paused = 1'b1;
        end
        queue_random_stimulus();
      end
      while (gen_pos != 0) queue_sample($urandom_range(0, POS_LIMIT), 1'b0);
      wait_for_drain();
      random_items += samples_queued - phase_start;
    end

    wait_for_drain();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/tmpds_pkg.sv
rtl/core/tmpds_in_if.sv
rtl/core/tmpds_out_if.sv
rtl/core/tmpds_front.sv
rtl/core/tmpds_queue.sv
rtl/core/tmpds_back.sv
rtl/core/touch_median_pen_detect_scaler.sv
bench/testbench.sv
